// ===== src/text_line_rotate_xor_hash_top_macros.svh =====
// Assertion macros shared by the text line hash RTL.
`ifndef TEXT_LINE_ROTATE_XOR_HASH_TOP_MACROS_SVH
`define TEXT_LINE_ROTATE_XOR_HASH_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, off during reset.
`define TLRXH_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication, sampled on clk, off during reset.
`define TLRXH_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`else

`define TLRXH_ASSERT_IMP(label, ante, cons)
`define TLRXH_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ===== src/tlrxh_pkg.sv =====
// Types and constants for the text line rotate-xor hash.
package tlrxh_pkg;

    // Marker matcher: "//-", V or v, 3 or 4 digits, trailing whitespace.
    typedef enum logic [9:0] {
        MS_IDLE = 10'b00_0000_0001,
        MS_S1   = 10'b00_0000_0010,
        MS_S2   = 10'b00_0000_0100,
        MS_S3   = 10'b00_0000_1000,
        MS_LET  = 10'b00_0001_0000,
        MS_D1   = 10'b00_0010_0000,
        MS_D2   = 10'b00_0100_0000,
        MS_D3   = 10'b00_1000_0000,
        MS_D4   = 10'b01_0000_0000,
        MS_WS   = 10'b10_0000_0000
    } match_state_t;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_UPV   = 8'h56;
    localparam logic [7:0] CH_LOWV  = 8'h76;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic MODE_LEGACY = 1'b0;
    localparam logic MODE_MARKER = 1'b1;

    localparam logic ADDR_HASH_MODE = 1'b0;

    function automatic logic is_ws6(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) ||
               (b == CH_CR) || (b == CH_VT) || (b == CH_FF);
    endfunction

    function automatic logic is_accepting(input match_state_t s);
        return (s == MS_D3) || (s == MS_D4) || (s == MS_WS);
    endfunction

endpackage

// ===== src/text_line_rotate_xor_hash_top.sv =====
// Text line rotate-xor hash: top level with matcher and hash datapath.
//
// Bytes of a line arrive on the byte channel (data_byte, no_byte, line_end,
// byte_valid/byte_stall). The item with line_end set closes the line and
// yields one 32-bit line_hash on the hash channel (hash_valid/hash_stall);
// other items yield nothing. no_byte marks an item that carries no byte,
// used to close an empty line, which hashes to 0.
// An item is taken into an input register, processed by one pass of logic
// (rotate, xor, marker matcher) and the hash lands in the result register,
// whose valid flag is hash_valid. One item is accepted per cycle while the
// result register is free or being drained. When hash_stall holds the
// result, the input register still fills once and byte_stall then rises
// until the result is taken.
// hash_mode (APB address 0, reset 1) selects marker stripping (1) or legacy
// digit/whitespace normalization (0); write it only while the block is idle.
// Reset clears all line state and both pipeline valid bits; no clearing pass.
module text_line_rotate_xor_hash_top (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // bytes
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  data_byte,
    input  logic        no_byte,
    input  logic        line_end,
    // hashes
    output logic        hash_valid,
    input  logic        hash_stall,
    output logic [31:0] line_hash
);

`include "text_line_rotate_xor_hash_top_macros.svh"

    logic                    mode_reg;
    logic                    s1_valid_reg;
    logic [7:0]              s1_byte_reg;
    logic                    s1_nob_reg;
    logic                    s1_end_reg;
    logic                    out_valid_reg;
    logic [31:0]             out_hash_reg;

    logic [31:0]             running_hash_reg, running_hash_next;
    logic [31:0]             lag0_reg, lag0_next;
    logic [31:0]             lag1_reg, lag1_next;
    logic [31:0]             chain_start_reg, chain_start_next;
    tlrxh_pkg::match_state_t match_state_reg, match_state_next;
    logic                    chain_valid_reg, chain_valid_next;
    logic                    prev_digit_reg, prev_digit_next;
    logic [31:0]             end_hash;

    logic advance;
    logic accept;
    logic cfg_write;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == tlrxh_pkg::ADDR_HASH_MODE) ? {31'd0, mode_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= tlrxh_pkg::MODE_MARKER;
        end
        else if (cfg_write && (paddr[2] == tlrxh_pkg::ADDR_HASH_MODE))
        begin
            mode_reg <= pwdata[0];
        end
    end

    // pipeline control
    assign advance    = s1_valid_reg && (!out_valid_reg || !hash_stall);
    assign byte_stall = s1_valid_reg && !advance;
    assign accept     = byte_valid && !byte_stall;
    assign hash_valid = out_valid_reg;
    assign line_hash  = out_hash_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance && s1_end_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!hash_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg <= data_byte;
            s1_nob_reg  <= no_byte;
            s1_end_reg  <= line_end;
        end
        if (advance && s1_end_reg)
        begin
            out_hash_reg <= end_hash;
        end
    end

    // one byte through hash and marker matcher
    always_comb
    begin
        logic [7:0] b;
        logic       digit;
        logic       high;
        logic       ws;
        logic       count;
        logic [7:0] sym;

        b     = s1_byte_reg;
        digit = (b >= tlrxh_pkg::CH_ZERO) && (b <= tlrxh_pkg::CH_NINE);
        high  = b[7];
        ws    = tlrxh_pkg::is_ws6(b);
        sym   = digit && (mode_reg == tlrxh_pkg::MODE_LEGACY) ? tlrxh_pkg::CH_UNDER : b;

        if (mode_reg == tlrxh_pkg::MODE_LEGACY)
        begin
            count = !high && !ws && (!digit || !prev_digit_reg);
        end
        else
        begin
            count = !high && (b != tlrxh_pkg::CH_SPACE) && (b != tlrxh_pkg::CH_TAB);
        end

        running_hash_next = running_hash_reg;
        lag0_next         = lag0_reg;
        lag1_next         = lag1_reg;
        chain_start_next  = chain_start_reg;
        match_state_next  = match_state_reg;
        chain_valid_next  = chain_valid_reg;
        prev_digit_next   = prev_digit_reg;

        if (!s1_nob_reg)
        begin
            match_state_next = tlrxh_pkg::MS_IDLE;
            chain_valid_next = 1'b0;
            if (b == tlrxh_pkg::CH_SLASH)
            begin
                unique case (match_state_reg)
                    tlrxh_pkg::MS_S1:
                    begin
                        match_state_next = tlrxh_pkg::MS_S2;
                        chain_valid_next = chain_valid_reg;
                    end
                    tlrxh_pkg::MS_S2:
                    begin
                        match_state_next = tlrxh_pkg::MS_S2;
                    end
                    default:
                    begin
                        // a slash right after a full marker may continue the chain
                        match_state_next = tlrxh_pkg::MS_S1;
                        chain_valid_next = tlrxh_pkg::is_accepting(match_state_reg);
                    end
                endcase
            end
            else if (b == tlrxh_pkg::CH_DASH)
            begin
                if (match_state_reg == tlrxh_pkg::MS_S2)
                begin
                    match_state_next = tlrxh_pkg::MS_S3;
                    // chain start is the hash ahead of the two slashes
                    if (!chain_valid_reg)
                    begin
                        chain_start_next = lag1_reg;
                    end
                end
            end
            else if ((b == tlrxh_pkg::CH_UPV) || (b == tlrxh_pkg::CH_LOWV))
            begin
                if (match_state_reg == tlrxh_pkg::MS_S3)
                begin
                    match_state_next = tlrxh_pkg::MS_LET;
                end
            end
            else if (digit)
            begin
                unique case (match_state_reg)
                    tlrxh_pkg::MS_LET: match_state_next = tlrxh_pkg::MS_D1;
                    tlrxh_pkg::MS_D1:  match_state_next = tlrxh_pkg::MS_D2;
                    tlrxh_pkg::MS_D2:  match_state_next = tlrxh_pkg::MS_D3;
                    tlrxh_pkg::MS_D3:  match_state_next = tlrxh_pkg::MS_D4;
                    default:           match_state_next = tlrxh_pkg::MS_IDLE;
                endcase
            end
            else if (ws)
            begin
                if (tlrxh_pkg::is_accepting(match_state_reg))
                begin
                    match_state_next = tlrxh_pkg::MS_WS;
                end
            end

            lag1_next       = lag0_reg;
            lag0_next       = running_hash_reg;
            prev_digit_next = digit;
            if (count)
            begin
                running_hash_next = {running_hash_reg[30:0], running_hash_reg[31]} ^
                                    {24'd0, sym};
            end
        end

        if ((mode_reg == tlrxh_pkg::MODE_MARKER) &&
            tlrxh_pkg::is_accepting(match_state_next))
        begin
            end_hash = chain_start_next;
        end
        else
        begin
            end_hash = running_hash_next;
        end

        if (s1_end_reg)
        begin
            running_hash_next = 32'd0;
            lag0_next         = 32'd0;
            lag1_next         = 32'd0;
            chain_start_next  = 32'd0;
            match_state_next  = tlrxh_pkg::MS_IDLE;
            chain_valid_next  = 1'b0;
            prev_digit_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_hash_reg <= 32'd0;
            lag0_reg         <= 32'd0;
            lag1_reg         <= 32'd0;
            chain_start_reg  <= 32'd0;
            match_state_reg  <= tlrxh_pkg::MS_IDLE;
            chain_valid_reg  <= 1'b0;
            prev_digit_reg   <= 1'b0;
        end
        else if (advance)
        begin
            running_hash_reg <= running_hash_next;
            lag0_reg         <= lag0_next;
            lag1_reg         <= lag1_next;
            chain_start_reg  <= chain_start_next;
            match_state_reg  <= match_state_next;
            chain_valid_reg  <= chain_valid_next;
            prev_digit_reg   <= prev_digit_next;
        end
    end

    `TLRXH_ASSERT_NXT(a_line_end_clears, advance && s1_end_reg,
        running_hash_reg == 32'd0 && !chain_valid_reg && !prev_digit_reg)
    `TLRXH_ASSERT_NXT(a_line_end_gives_hash, advance && s1_end_reg, out_valid_reg)
    `TLRXH_ASSERT_IMP(a_chain_in_prefix, chain_valid_reg,
        match_state_reg == tlrxh_pkg::MS_S1 || match_state_reg == tlrxh_pkg::MS_S2)
    `TLRXH_ASSERT_NXT(a_lag_shift, advance && !s1_nob_reg && !s1_end_reg,
        lag0_reg == $past(running_hash_reg) && lag1_reg == $past(lag0_reg))

endmodule

// ===== sim/testbench.sv =====
// Testbench for the text line rotate-xor hash: directed and random lines.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int REG_SPARE_IDX = 1;    // no register here; writes must be ignored

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        byte_valid = 1'b0;
    logic        byte_stall;
    logic [7:0]  data_byte = '0;
    logic        no_byte = 1'b0;
    logic        line_end = 1'b0;
    logic        hash_valid;
    logic        hash_stall = 1'b0;
    logic [31:0] line_hash;

    text_line_rotate_xor_hash_top dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .byte_valid(byte_valid), .byte_stall(byte_stall), .data_byte(data_byte),
        .no_byte(no_byte), .line_end(line_end),
        .hash_valid(hash_valid), .hash_stall(hash_stall), .line_hash(line_hash)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // predictor state, one line at a time
    logic                    cfg_mode = tlrxh_pkg::MODE_MARKER;
    logic [31:0]             line_acc = '0;
    logic [31:0]             lag_near = '0;
    logic [31:0]             lag_far = '0;
    logic [31:0]             chain_base = '0;
    tlrxh_pkg::match_state_t mstate = tlrxh_pkg::MS_IDLE;
    logic                    chain_ok = 1'b0;
    logic                    last_digit = 1'b0;

    logic [31:0]  pending_line_hashes[$];
    bit           quiet = 1'b0;
    int           mismatches = 0;
    int           hashes_checked = 0;
    int           items_sent = 0;
    int           lines_sent = 0;
    int           cycles = 0;

    function automatic logic ws_byte(input logic [7:0] b);
        return b == tlrxh_pkg::CH_SPACE || b == tlrxh_pkg::CH_TAB ||
               b == tlrxh_pkg::CH_LF || b == tlrxh_pkg::CH_CR ||
               b == tlrxh_pkg::CH_VT || b == tlrxh_pkg::CH_FF;
    endfunction

    function automatic logic marker_done(input tlrxh_pkg::match_state_t s);
        return s == tlrxh_pkg::MS_D3 || s == tlrxh_pkg::MS_D4 || s == tlrxh_pkg::MS_WS;
    endfunction

    // Advance the line state by one accepted item; queue a hash on line end.
    function automatic void line_hash_step(input logic [7:0] b, input logic nb,
                                           input logic fin);
        logic [31:0]             prior;
        logic [31:0]             h;
        logic [7:0]              sym;
        logic                    dig;
        logic                    take;
        tlrxh_pkg::match_state_t n;
        if (!nb)
        begin
            dig = b >= tlrxh_pkg::CH_ZERO && b <= tlrxh_pkg::CH_NINE;
            sym = b;
            prior = line_acc;
            if (cfg_mode == tlrxh_pkg::MODE_LEGACY)
            begin
                if (b[7] || ws_byte(b))
                    take = 1'b0;
                else if (dig)
                begin
                    take = !last_digit;
                    sym = tlrxh_pkg::CH_UNDER;
                end
                else
                    take = 1'b1;
            end
            else
                take = !b[7] && b != tlrxh_pkg::CH_SPACE && b != tlrxh_pkg::CH_TAB;

            n = tlrxh_pkg::MS_IDLE;
            if (b == tlrxh_pkg::CH_SLASH)
            begin
                if (mstate == tlrxh_pkg::MS_S1)
                    n = tlrxh_pkg::MS_S2;
                else if (mstate == tlrxh_pkg::MS_S2)
                begin
                    n = tlrxh_pkg::MS_S2;
                    chain_ok = 1'b0;
                end
                else
                begin
                    n = tlrxh_pkg::MS_S1;
                    chain_ok = marker_done(mstate);
                end
            end
            else if (b == tlrxh_pkg::CH_DASH)
            begin
                if (mstate == tlrxh_pkg::MS_S2)
                begin
                    n = tlrxh_pkg::MS_S3;
                    // chain begins before the last two slashes of this marker
                    if (!chain_ok)
                        chain_base = lag_far;
                    chain_ok = 1'b0;
                end
            end
            else if (b == tlrxh_pkg::CH_UPV || b == tlrxh_pkg::CH_LOWV)
            begin
                if (mstate == tlrxh_pkg::MS_S3)
                    n = tlrxh_pkg::MS_LET;
            end
            else if (dig)
            begin
                case (mstate)
                    tlrxh_pkg::MS_LET: n = tlrxh_pkg::MS_D1;
                    tlrxh_pkg::MS_D1:  n = tlrxh_pkg::MS_D2;
                    tlrxh_pkg::MS_D2:  n = tlrxh_pkg::MS_D3;
                    tlrxh_pkg::MS_D3:  n = tlrxh_pkg::MS_D4;
                    default:           n = tlrxh_pkg::MS_IDLE;
                endcase
            end
            else if (ws_byte(b))
            begin
                if (marker_done(mstate))
                    n = tlrxh_pkg::MS_WS;
            end
            if (n != tlrxh_pkg::MS_S1 && n != tlrxh_pkg::MS_S2 && n != tlrxh_pkg::MS_S3)
                chain_ok = 1'b0;
            mstate = n;

            lag_far = lag_near;
            lag_near = prior;
            if (take)
                line_acc = {line_acc[30:0], line_acc[31]} ^ {24'b0, sym};
            last_digit = dig;
        end
        if (fin)
        begin
            h = (cfg_mode == tlrxh_pkg::MODE_MARKER && marker_done(mstate)) ?
                chain_base : line_acc;
            pending_line_hashes.insert(pending_line_hashes.size(), h);
            line_acc = '0;
            lag_near = '0;
            lag_far = '0;
            chain_base = '0;
            mstate = tlrxh_pkg::MS_IDLE;
            chain_ok = 1'b0;
            last_digit = 1'b0;
            lines_sent++;
        end
    endfunction

    // Valid stays high after acceptance; the next send or settle() takes it over.
    task automatic send_item(input logic [7:0] b, input logic nb, input logic fin);
        while (!quiet && $urandom_range(99) < 6)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        data_byte <= b;
        no_byte <= nb;
        line_end <= fin;
        do @(posedge clk); while (byte_stall);
        line_hash_step(b, nb, fin);
        if (!nb || fin)
            items_sent++;
    endtask

    // Wait until every hash is back, plus the pipeline depth for hashless items.
    task automatic settle();
        byte_valid <= 1'b0;
        @(posedge clk);
        while (pending_line_hashes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic reg_write(input int idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(idx * 4);
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (idx == int'(tlrxh_pkg::ADDR_HASH_MODE))
            cfg_mode = value[0];
        @(posedge clk);
    endtask

    task automatic check_mode_readback();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= 3'(int'(tlrxh_pkg::ADDR_HASH_MODE) * 4);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[0] !== cfg_mode)
        begin
            $display("%0t: hash_mode readback mismatch: expected %0b, got %0b",
                     $time, cfg_mode, prdata[0]);
            mismatches++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_mode(input logic mode);
        settle();
        reg_write(int'(tlrxh_pkg::ADDR_HASH_MODE),
                  {31'($urandom_range(32'h7FFF_FFFF, 0)), mode});
        check_mode_readback();
    endtask

    function automatic logic [7:0] pick_ws();
        case ($urandom_range(5))
            0: return tlrxh_pkg::CH_SPACE;
            1: return tlrxh_pkg::CH_TAB;
            2: return tlrxh_pkg::CH_LF;
            3: return tlrxh_pkg::CH_CR;
            4: return tlrxh_pkg::CH_VT;
            default: return tlrxh_pkg::CH_FF;
        endcase
    endfunction

    function automatic logic [7:0] pick_digit();
        return tlrxh_pkg::CH_ZERO + 8'($urandom_range(9));
    endfunction

    // One "//-Vddd ws" marker, sometimes with extra slashes, odd digit counts or cut short.
    function automatic void add_marker(ref logic [7:0] q[$]);
        logic [7:0] m[$];
        int         ndig;
        int         r;
        int         cut;
        if ($urandom_range(9) == 0)
            m.insert(m.size(), tlrxh_pkg::CH_SLASH);
        m.insert(m.size(), tlrxh_pkg::CH_SLASH);
        m.insert(m.size(), tlrxh_pkg::CH_SLASH);
        m.insert(m.size(), tlrxh_pkg::CH_DASH);
        m.insert(m.size(), $urandom_range(1) ? tlrxh_pkg::CH_UPV : tlrxh_pkg::CH_LOWV);
        r = $urandom_range(99);
        ndig = (r < 45) ? 3 : (r < 90) ? 4 : (r < 95) ? 5 : 2;
        repeat (ndig) m.insert(m.size(), pick_digit());
        repeat ($urandom_range(2)) m.insert(m.size(), pick_ws());
        cut = ($urandom_range(99) < 15) ? $urandom_range(m.size() - 1) : m.size();
        for (int i = 0; i < cut; i++)
            q.insert(q.size(), m[i]);
    endfunction

    task automatic send_random_line();
        logic [7:0] q[$];
        logic       split_end;
        int         n;
        repeat ($urandom_range(4))
        begin
            n = $urandom_range(1, 4);
            case ($urandom_range(9))
                0, 1: repeat (n) q.insert(q.size(), 8'($urandom_range(255)));
                2, 3: repeat (n) q.insert(q.size(), 8'($urandom_range(8'h7E, 8'h21)));
                4:    repeat ($urandom_range(1, 5)) q.insert(q.size(), pick_digit());
                5:    repeat (n) q.insert(q.size(), pick_ws());
                default: add_marker(q);
            endcase
        end
        // trailing chains are what the stripping logic is about
        if ($urandom_range(99) < 60)
            repeat ($urandom_range(1, 3)) add_marker(q);
        split_end = $urandom_range(99) < 30;
        if ($urandom_range(99) < 3)
            settle();
        foreach (q[i])
        begin
            if ($urandom_range(99) < 3)
                send_item(8'($urandom_range(255)), 1'b1, 1'b0);
            send_item(q[i], 1'b0, i == q.size() - 1 && !split_end);
        end
        if (q.size() == 0 || split_end)
            send_item(8'($urandom_range(255)), 1'b1, 1'b1);
    endtask

    task automatic test_empty_and_extremes();
        send_item(8'h00, 1'b1, 1'b0);      // no byte, no end: nothing
        send_item(8'hFF, 1'b1, 1'b1);      // empty line
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(tlrxh_pkg::CH_SPACE, 1'b0, 1'b0);
        send_item(tlrxh_pkg::CH_TAB, 1'b0, 1'b0);
        send_item(tlrxh_pkg::CH_LF, 1'b0, 1'b0);
        send_item(8'h7F, 1'b0, 1'b1);
    endtask

    task automatic test_marker_strip();
        logic [7:0] txt[$];
        txt = '{8'h71, tlrxh_pkg::CH_SLASH, tlrxh_pkg::CH_SLASH, tlrxh_pkg::CH_DASH,
                tlrxh_pkg::CH_UPV, 8'h31, 8'h32, 8'h33, tlrxh_pkg::CH_SPACE};
        foreach (txt[i])
            send_item(txt[i], 1'b0, i == txt.size() - 1);
    endtask

    task automatic test_legacy_normalize();
        logic [7:0] txt[$];
        set_mode(tlrxh_pkg::MODE_LEGACY);
        txt = '{8'h41, tlrxh_pkg::CH_SPACE, 8'h31, 8'h32, tlrxh_pkg::CH_TAB, 8'h33,
                8'h80, 8'h42};
        foreach (txt[i])
            send_item(txt[i], 1'b0, i == txt.size() - 1);
    endtask

    // mode flips between bytes of one line
    task automatic test_mode_switch_midline();
        send_item(8'h37, 1'b0, 1'b0);
        send_item(8'h38, 1'b0, 1'b0);
        set_mode(tlrxh_pkg::MODE_MARKER);
        send_item(8'h39, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
    endtask

    task automatic test_spare_register();
        settle();
        check_mode_readback();
        reg_write(REG_SPARE_IDX, 32'h0000_0000);
        check_mode_readback();
    endtask

    task automatic test_random_lines(input int target);
        int start;
        start = items_sent;
        while (items_sent - start < target)
            send_random_line();
    endtask

    // hash channel: random stalls and in-order comparison
    always @(posedge clk)
    begin : hash_check
        logic [31:0] want;
        if (rst_n)
        begin
            if (hash_valid && !hash_stall)
            begin
                if (pending_line_hashes.size() == 0)
                begin
                    $display("%0t: line_hash %08h arrived with none expected",
                             $time, line_hash);
                    mismatches++;
                end
                else
                begin
                    want = pending_line_hashes.pop_front();
                    hashes_checked++;
                    if (line_hash !== want)
                    begin
                        $display("%0t: line_hash mismatch: expected %08h, got %08h",
                                 $time, want, line_hash);
                        mismatches++;
                    end
                end
            end
            hash_stall <= !quiet && $urandom_range(99) < 6;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d hashes outstanding",
                     cycles, pending_line_hashes.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_extremes();
        test_marker_strip();
        test_legacy_normalize();
        test_mode_switch_midline();
        test_spare_register();

        test_random_lines(450);
        set_mode(tlrxh_pkg::MODE_LEGACY);
        test_random_lines(300);
        quiet = 1'b1;
        test_random_lines(200);
        set_mode(tlrxh_pkg::MODE_MARKER);
        test_random_lines(300);
        quiet = 1'b0;
        test_random_lines(300);
        settle();

        $display("Sent %0d items in %0d lines; %0d hashes checked, %0d mismatches.",
                 items_sent, lines_sent, hashes_checked, mismatches);
        $display("Both modes, mid-line mode change, marker chains whole and broken, stalls.");
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
